// ===== rtl/core/prim_mst_pkg.sv =====
// Shared types and constants for the minimum spanning tree block.
`timescale 1ns / 1ps
package prim_mst_pkg;
	localparam int MAX_VERTICES = 32;
	localparam int MAX_EDGES    = 256;
	localparam int WEIGHT_BITS  = 16;
	localparam int VIDX_W       = $clog2(MAX_VERTICES);
	localparam int VCNT_W       = VIDX_W + 1;
	localparam int EIDX_W       = $clog2(MAX_EDGES);
	localparam int ECNT_W       = EIDX_W + 1;
	localparam int COST_W       = 21;
	localparam int ACC_W        = COST_W + 1;
	localparam int QUEUE_DEPTH  = 4;
	localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
	localparam int KEY_W        = WEIGHT_BITS + 2 * VIDX_W;

	typedef enum logic [1:0] {
		OP_LOAD    = 2'd0,
		OP_COMPUTE = 2'd1,
		OP_CLEAR   = 2'd2
	} op_t;

	// One classified request travelling from the front to the back.
	typedef struct packed {
		op_t                            op;
		logic [VIDX_W-1:0]              src;
		logic [VIDX_W-1:0]              tgt;
		logic signed [WEIGHT_BITS-1:0]  weight;
	} req_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_COMMIT,
		ST_EMIT
	} state_t;
endpackage

// ===== rtl/core/prim_mst_front.sv =====
// Front part: accepts requests, drops unused codes and queues the rest.
`timescale 1ns / 1ps
module prim_mst_front import prim_mst_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [1:0]        in_op,
	input  logic [VIDX_W-1:0] in_src,
	input  logic [VIDX_W-1:0] in_tgt,
	input  logic [WEIGHT_BITS-1:0] in_weight,
	output logic              q_valid,
	output req_t              q_head,
	input  logic              q_pop
);
	req_t              slot_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_q;
	logic [QPTR_W-1:0] rd_q;
	logic [QPTR_W:0]   cnt_q;
	logic              known_op;
	logic              push;

	// Only load, compute and clear requests enter the queue.
	assign known_op = (in_op == OP_LOAD) || (in_op == OP_COMPUTE) || (in_op == OP_CLEAR);
	assign in_ready = (cnt_q != QUEUE_DEPTH[QPTR_W:0]);
	assign push     = in_valid && in_ready && known_op;
	assign q_valid  = (cnt_q != '0);
	assign q_head   = slot_q[rd_q];

	// Queue storage.
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= '{op: op_t'(in_op), src: in_src, tgt: in_tgt,
				weight: $signed(in_weight)};
		end
	end

	// Queue pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (q_pop) rd_q <= rd_q + 1'b1;
			cnt_q <= cnt_q + {{QPTR_W{1'b0}}, push} - {{QPTR_W{1'b0}}, q_pop};
		end
	end
endmodule

// ===== rtl/core/prim_mst_back.sv =====
// Back part: edge store, Prim walk over the store and result emission.
`timescale 1ns / 1ps
module prim_mst_back import prim_mst_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [5:0]        cfg_wdata,
	input  logic              q_valid,
	input  req_t              q_head,
	output logic              q_pop,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [VIDX_W-1:0] out_vertex,
	output logic [VCNT_W-1:0] out_parent,
	output logic [COST_W-1:0] out_cost,
	output logic              out_complete,
	output logic              out_dropped,
	output logic              out_last
);
	logic [KEY_W-1:0]   mem_q [MAX_EDGES];
	logic [KEY_W-1:0]   rd_data_s1;
	logic               rd_valid_s1;
	logic [5:0]         vcount_q;
	logic [ECNT_W-1:0]  ecount_q;
	logic               ovf_q;
	state_t             state_q, state_d;
	logic [VCNT_W-1:0]  n_q;
	logic [MAX_VERTICES-1:0] tree_q;
	logic [VCNT_W-1:0]  parent_q [MAX_VERTICES];
	logic [ECNT_W-1:0]  addr_q;
	logic               found_q;
	logic [KEY_W-1:0]   best_q;
	logic [VCNT_W-1:0]  used_q;
	logic signed [ACC_W-1:0] cost_q;
	logic [VIDX_W-1:0]  emit_q;
	logic [VCNT_W-1:0]  n_clamp;
	logic [VIDX_W-1:0]  rd_src, rd_tgt, best_src, best_tgt;
	logic [WEIGHT_BITS-1:0] rd_w, best_w;
	logic [KEY_W-1:0]   rd_key;
	logic               eligible;
	logic               scan_done;
	logic               emit_go;
	logic               emit_last;
	logic signed [COST_W-1:0] cost_sat;

	// Stored entries are kept as {weight, target, source}.
	assign rd_w     = rd_data_s1[KEY_W-1 -: WEIGHT_BITS];
	assign rd_tgt   = rd_data_s1[2*VIDX_W-1 -: VIDX_W];
	assign rd_src   = rd_data_s1[VIDX_W-1:0];
	assign best_w   = best_q[KEY_W-1 -: WEIGHT_BITS];
	assign best_tgt = best_q[2*VIDX_W-1 -: VIDX_W];
	assign best_src = best_q[VIDX_W-1:0];
	// Ordering key: signed weight with sign flipped, then target, then source.
	assign rd_key   = {~rd_w[WEIGHT_BITS-1], rd_w[WEIGHT_BITS-2:0], rd_tgt, rd_src};
	assign eligible = rd_valid_s1 && tree_q[rd_src] && ({1'b0, rd_tgt} < n_q)
		&& !tree_q[rd_tgt];
	assign scan_done = (addr_q >= ecount_q) && !rd_valid_s1;

	// Clamp vertex count into 1..MAX_VERTICES.
	always_comb begin
		if (vcount_q == '0) begin
			n_clamp = VCNT_W'(1);
		end else if (vcount_q > 6'(MAX_VERTICES)) begin
			n_clamp = VCNT_W'(MAX_VERTICES);
		end else begin
			n_clamp = vcount_q[VCNT_W-1:0];
		end
	end

	// Saturate the accumulated cost to the result range.
	always_comb begin
		if (cost_q > $signed({2'b00, {(COST_W-1){1'b1}}})) begin
			cost_sat = {1'b0, {(COST_W-1){1'b1}}};
		end else if (cost_q < $signed({2'b11, {(COST_W-1){1'b0}}})) begin
			cost_sat = {1'b1, {(COST_W-1){1'b0}}};
		end else begin
			cost_sat = cost_q[COST_W-1:0];
		end
	end

	assign emit_go   = (state_q == ST_EMIT) && (!out_valid || out_ready);
	assign emit_last = ({1'b0, emit_q} + 1'b1) == n_q;
	assign q_pop     = (state_q == ST_IDLE) && q_valid;

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (q_valid && q_head.op == OP_COMPUTE) begin
					state_d = (n_clamp == VCNT_W'(1)) ? ST_EMIT : ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (scan_done) state_d = ST_COMMIT;
			end
			ST_COMMIT: begin
				if (found_q && ({1'b0, used_q} + 7'd2 < {1'b0, n_q})) begin
					state_d = ST_SCAN;
				end else begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (emit_go && emit_last) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Edge store with registered read.
	always_ff @(posedge clk) begin
		if (q_pop && q_head.op == OP_LOAD && !ecount_q[EIDX_W]) begin
			mem_q[ecount_q[EIDX_W-1:0]] <= {q_head.weight, q_head.tgt, q_head.src};
		end
		rd_data_s1 <= mem_q[addr_q[EIDX_W-1:0]];
	end

	// Control and walk state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			vcount_q    <= 6'(MAX_VERTICES);
			ecount_q    <= '0;
			ovf_q       <= 1'b0;
			n_q         <= VCNT_W'(MAX_VERTICES);
			tree_q      <= '0;
			addr_q      <= '0;
			rd_valid_s1 <= 1'b0;
			found_q     <= 1'b0;
			best_q      <= '0;
			used_q      <= '0;
			cost_q      <= '0;
			emit_q      <= '0;
			out_valid   <= 1'b0;
			for (int i = 0; i < MAX_VERTICES; i++) parent_q[i] <= '1;
		end else begin
			state_q <= state_d;
			if (cfg_we) vcount_q <= cfg_wdata;
			if (out_valid && out_ready && !emit_go) out_valid <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (q_valid) begin
						case (q_head.op)
							OP_LOAD: begin
								if (ecount_q[EIDX_W]) ovf_q <= 1'b1;
								else ecount_q <= ecount_q + 1'b1;
							end
							OP_CLEAR: begin
								ecount_q <= '0;
								ovf_q    <= 1'b0;
							end
							OP_COMPUTE: begin
								n_q     <= n_clamp;
								tree_q  <= MAX_VERTICES'(1);
								used_q  <= '0;
								cost_q  <= '0;
								addr_q  <= '0;
								found_q <= 1'b0;
								emit_q  <= '0;
								for (int i = 0; i < MAX_VERTICES; i++) parent_q[i] <= '1;
							end
							default: ;
						endcase
					end
				end
				ST_SCAN: begin
					// Issue one read per cycle, compare one entry per cycle.
					if (addr_q < ecount_q) begin
						addr_q      <= addr_q + 1'b1;
						rd_valid_s1 <= 1'b1;
					end else begin
						rd_valid_s1 <= 1'b0;
					end
					if (eligible && (!found_q || rd_key < best_q)) begin
						found_q <= 1'b1;
						best_q  <= rd_key;
					end
				end
				ST_COMMIT: begin
					if (found_q) begin
						tree_q[best_tgt]   <= 1'b1;
						parent_q[best_tgt] <= {1'b0, best_src};
						cost_q  <= cost_q + ACC_W'($signed({~best_w[WEIGHT_BITS-1],
							best_w[WEIGHT_BITS-2:0]}));
						used_q  <= used_q + 1'b1;
					end
					addr_q  <= '0;
					found_q <= 1'b0;
				end
				ST_EMIT: begin
					if (emit_go) begin
						out_valid    <= 1'b1;
						out_vertex   <= emit_q;
						out_parent   <= parent_q[emit_q];
						out_last     <= emit_last;
						out_cost     <= emit_last ? cost_sat : '0;
						out_complete <= emit_last && ((used_q + 1'b1) == n_q);
						out_dropped  <= emit_last && ovf_q;
						emit_q       <= emit_q + 1'b1;
					end
				end
				default: ;
			endcase
		end
	end
endmodule

// ===== rtl/core/prim_minimum_spanning_tree.sv =====
// Top level of the minimum spanning tree block.
// Loads and clears stream at one request per cycle while no compute runs.
// A compute walks the stored edges once per step with one compare per stored edge,
// then emits one result per cycle while the result side is ready.
// No new request is started while a compute runs; the queue holds four.
// Asynchronous active-low reset: empty store, vertex count 32, all parents -1.
`timescale 1ns / 1ps
module prim_minimum_spanning_tree import prim_mst_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// operation[1:0]
	input  logic [1:0]  s_tuser,
	// edge_source[4:0], edge_target[9:5], edge_weight[25:10]
	input  logic [31:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	// vertex[4:0], parent_vertex[10:5], tree_cost[31:11], tree_complete[32],
	// edges_dropped[33]
	output logic [39:0] m_tdata,
	output logic        m_tlast,
	input  logic        cfg_we,
	input  logic [5:0]  cfg_wdata
);
	logic              q_valid;
	req_t              q_head;
	logic              q_pop;
	logic [VIDX_W-1:0] vertex;
	logic [VCNT_W-1:0] parent;
	logic [COST_W-1:0] cost;
	logic              complete;
	logic              dropped;

	prim_mst_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_op     (s_tuser),
		.in_src    (s_tdata[4:0]),
		.in_tgt    (s_tdata[9:5]),
		.in_weight (s_tdata[25:10]),
		.q_valid   (q_valid),
		.q_head    (q_head),
		.q_pop     (q_pop)
	);

	prim_mst_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.q_valid      (q_valid),
		.q_head       (q_head),
		.q_pop        (q_pop),
		.out_valid    (m_tvalid),
		.out_ready    (m_tready),
		.out_vertex   (vertex),
		.out_parent   (parent),
		.out_cost     (cost),
		.out_complete (complete),
		.out_dropped  (dropped),
		.out_last     (m_tlast)
	);

	assign m_tdata = {6'b0, dropped, complete, cost, parent, vertex};
endmodule

// ===== rtl/core/prim_mst_checker.sv =====
// Port-level checks for the minimum spanning tree block.
`timescale 1ns / 1ps
module prim_mst_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [39:0] m_tdata,
	input logic        m_tlast
);
	logic [4:0] expect_q;

	// Expected vertex number of the next result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expect_q <= '0;
		end else if (m_tvalid && m_tready) begin
			expect_q <= m_tlast ? 5'd0 : expect_q + 1'b1;
		end
	end

	// Results report vertices in order, starting from zero.
	a_order: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[4:0] == expect_q) else $error("vertex out of order");

	// The root never has a parent.
	a_root: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[4:0] == 5'd0) |-> m_tdata[10:5] == 6'h3f)
		else $error("root has a parent");

	// Summary fields are zero except on the last result.
	a_summary: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tlast) |-> m_tdata[33:11] == '0)
		else $error("summary on non-last result");

	// A stalled result holds.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("stalled result changed");
endmodule

bind prim_minimum_spanning_tree prim_mst_checker u_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast)
);

// ===== sim/tb_prim_minimum_spanning_tree.sv =====
// Self-checking testbench for the minimum spanning tree block.
`timescale 1ns / 1ps
module tb_prim_minimum_spanning_tree;
	import prim_mst_pkg::*;

	localparam int LOAD_SETTLE = 64;

	typedef struct packed {
		logic [4:0]         vertex;
		logic signed [5:0]  parent;
		logic signed [20:0] cost;
		logic               complete;
		logic               dropped;
		logic               last;
	} tree_row_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [1:0]  s_tuser;
	logic [31:0] s_tdata;
	logic        m_tvalid;
	logic        m_tready;
	logic [39:0] m_tdata;
	logic        m_tlast;
	logic        cfg_we;
	logic [5:0]  cfg_wdata;

	prim_minimum_spanning_tree dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tuser(s_tuser), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
	);

	// Predictor state: edge store, overflow flag and vertex count.
	logic [4:0]         store_src [MAX_EDGES];
	logic [4:0]         store_tgt [MAX_EDGES];
	logic signed [15:0] store_wt  [MAX_EDGES];
	int                 store_count;
	bit                 store_overflow;
	int                 model_vcount;

	// Pending requests: operation[1:0], source[6:2], target[11:7], weight[27:12].
	logic [31:0] pending_requests[$];
	tree_row_t   expected_rows[$];
	int          error_count;
	int          rows_checked;
	int          computes_sent;
	bit          driver_done;

	// Clock.
	initial clk = 1'b0;
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Work out the spanning tree for the current store and queue its rows.
	function automatic void predict_tree();
		bit                 joined [32];
		int                 parent [32];
		logic [4:0]         c_src [$];
		logic [4:0]         c_tgt [$];
		logic signed [15:0] c_wt  [$];
		int                 n, used, best, i;
		int                 u;
		logic [4:0]         ps, pt;
		longint             cost;
		tree_row_t          row;
		n = model_vcount < 1 ? 1 : (model_vcount > MAX_VERTICES ? MAX_VERTICES : model_vcount);
		for (i = 0; i < 32; i++) begin
			joined[i] = 0;
			parent[i] = -1;
		end
		used = 0;
		cost = 0;
		joined[0] = 1;
		u = 0;
		while (1) begin
			// Offer the new tree vertex's outgoing edges.
			for (i = 0; i < store_count; i++) begin
				if (store_src[i] == u && store_tgt[i] < n && !joined[store_tgt[i]]) begin
					c_src.push_back(store_src[i]);
					c_tgt.push_back(store_tgt[i]);
					c_wt.push_back(store_wt[i]);
				end
			end
			u = -1;
			while (u < 0 && used + 1 < n && c_src.size() > 0) begin
				best = 0;
				for (i = 1; i < c_src.size(); i++) begin
					if (c_wt[i] < c_wt[best] || (c_wt[i] == c_wt[best] &&
						(c_tgt[i] < c_tgt[best] || (c_tgt[i] == c_tgt[best] &&
						c_src[i] < c_src[best]))))
						best = i;
				end
				ps = c_src[best];
				pt = c_tgt[best];
				cost += c_wt[best];
				c_src.delete(best);
				c_tgt.delete(best);
				c_wt.delete(best);
				if (!joined[pt]) begin
					joined[pt] = 1;
					parent[pt] = ps;
					used++;
					u = pt;
				end
			end
			if (u < 0)
				break;
		end
		// The cost sum above added skipped edges too; recompute from the parents.
		cost = 0;
		for (i = 1; i < n; i++) begin
			if (parent[i] >= 0) begin
				best = -1;
				for (int k = 0; k < store_count; k++) begin
					if (store_src[k] == parent[i] && store_tgt[k] == i &&
						(best < 0 || store_wt[k] < store_wt[best]))
						best = k;
				end
				cost += store_wt[best];
			end
		end
		if (cost > 1048575) cost = 1048575;
		if (cost < -1048576) cost = -1048576;
		for (i = 0; i < n; i++) begin
			row = '0;
			row.vertex = 5'(i);
			row.parent = 6'(parent[i]);
			if (i == n - 1) begin
				row.cost = 21'(cost);
				row.complete = (used + 1 == n);
				row.dropped = store_overflow;
				row.last = 1'b1;
			end
			expected_rows.push_back(row);
		end
	endfunction

	// Apply one accepted request to the predictor.
	function automatic void predict_request(logic [31:0] req);
		op_t op;
		op = op_t'(req[1:0]);
		case (op)
			OP_LOAD: begin
				if (store_count < MAX_EDGES) begin
					store_src[store_count] = req[6:2];
					store_tgt[store_count] = req[11:7];
					store_wt[store_count] = req[27:12];
					store_count++;
				end else begin
					store_overflow = 1;
				end
			end
			OP_COMPUTE: predict_tree();
			OP_CLEAR: begin
				store_count = 0;
				store_overflow = 0;
			end
			default: ;
		endcase
	endfunction

	// Driver: one request at a time with a random gap before each.
	int send_gap;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tuser <= '0;
			s_tdata <= '0;
			send_gap <= $urandom_range(0, 19);
		end else if (s_tvalid && s_tready) begin
			predict_request(pending_requests[0]);
			void'(pending_requests.pop_front());
			s_tvalid <= 1'b0;
			send_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
		end else if (!s_tvalid && !driver_done && pending_requests.size() > 0) begin
			if (pending_requests[0] === 32'hFFFF_FFFF) begin
				// Hold off until the block has delivered everything.
				if (expected_rows.size() == 0)
					void'(pending_requests.pop_front());
			end else if (send_gap == 0) begin
				s_tvalid <= 1'b1;
				s_tuser <= pending_requests[0][1:0];
				s_tdata <= {6'b0, pending_requests[0][27:2]};
			end else begin
				send_gap <= send_gap - 1;
			end
		end
	end

	// Monitor: random stalls on the result side, field-wise compare.
	int recv_gap;
	tree_row_t got, want;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			recv_gap <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				got = '0;
				got.vertex = m_tdata[4:0];
				got.parent = m_tdata[10:5];
				got.cost = m_tdata[31:11];
				got.complete = m_tdata[32];
				got.dropped = m_tdata[33];
				got.last = m_tlast;
				if (expected_rows.size() == 0) begin
					$error("unexpected result row: vertex %0d", got.vertex);
					error_count++;
				end else begin
					want = expected_rows.pop_front();
					rows_checked++;
					if (got.vertex !== want.vertex) begin
						$error("vertex: expected %0d, got %0d", want.vertex, got.vertex);
						error_count++;
					end
					if (got.parent !== want.parent) begin
						$error("parent_vertex: expected %0d, got %0d", want.parent, got.parent);
						error_count++;
					end
					if (got.cost !== want.cost) begin
						$error("tree_cost: expected %0d, got %0d", want.cost, got.cost);
						error_count++;
					end
					if (got.complete !== want.complete) begin
						$error("tree_complete: expected %0d, got %0d", want.complete,
							got.complete);
						error_count++;
					end
					if (got.dropped !== want.dropped) begin
						$error("edges_dropped: expected %0d, got %0d", want.dropped,
							got.dropped);
						error_count++;
					end
					if (got.last !== want.last) begin
						$error("last: expected %0d, got %0d", want.last, got.last);
						error_count++;
					end
				end
			end
			if (recv_gap == 0) begin
				m_tready <= 1'b1;
				if (m_tvalid && m_tready)
					recv_gap <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 19);
			end else begin
				m_tready <= 1'b0;
				recv_gap <= recv_gap - 1;
			end
		end
	end

	function automatic logic [31:0] make_req(op_t op, int src, int tgt, int wt);
		logic [31:0] r;
		logic [15:0] w16;
		w16 = 16'(wt);
		r = '0;
		r[1:0] = op;
		r[6:2] = 5'(src);
		r[11:7] = 5'(tgt);
		r[27:12] = w16;
		return r;
	endfunction

	// Random graph on n vertices: random edges, one in ten drawn from all 32 vertices, some reversed.
	task automatic queue_graph(int n, int edges, int wt_span);
		int a, b;
		pending_requests.push_back(make_req(OP_CLEAR, 0, 0, 0));
		for (int e = 0; e < edges; e++) begin
			a = $urandom_range(0, n - 1);
			b = $urandom_range(0, n - 1);
			if ($urandom_range(0, 9) == 0) begin
				a = $urandom_range(0, 31);
				b = $urandom_range(0, 31);
			end
			pending_requests.push_back(make_req(OP_LOAD, a, b,
				$urandom_range(0, 1) ? $urandom_range(0, wt_span) :
				-int'($urandom_range(0, wt_span))));
			if ($urandom_range(0, 3) == 0)
				pending_requests.push_back(make_req(OP_LOAD, b, a,
					int'($urandom_range(0, 65535)) - 32768));
		end
		pending_requests.push_back(make_req(OP_COMPUTE, $urandom_range(0, 31),
			$urandom_range(0, 31), $urandom_range(0, 65535)));
		computes_sent++;
	endtask

	// Wait for the block to go quiet, then write the vertex count.
	task automatic set_vertex_count(logic [5:0] value);
		while (pending_requests.size() > 0 || s_tvalid || expected_rows.size() > 0)
			@(posedge clk);
		repeat (LOAD_SETTLE) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		model_vcount = value;
	endtask

	// Stimulus.
	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		driver_done = 0;
		error_count = 0;
		rows_checked = 0;
		computes_sent = 0;
		store_count = 0;
		store_overflow = 0;
		model_vcount = 32;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: reset count of 32 on an empty store, then extremes.
		pending_requests.push_back(make_req(OP_COMPUTE, 0, 0, 0));
		pending_requests.push_back(make_req(OP_LOAD, 0, 31, -32768));
		pending_requests.push_back(make_req(OP_LOAD, 31, 0, 32767));
		pending_requests.push_back(make_req(OP_LOAD, 0, 0, 5));
		pending_requests.push_back(make_req(OP_LOAD, 0, 1, 7));
		pending_requests.push_back(make_req(OP_LOAD, 0, 1, 7));
		pending_requests.push_back(make_req(OP_LOAD, 31, 1, 7));
		pending_requests.push_back(32'h0FFF_FFFF | 32'h3);
		pending_requests.push_back(make_req(OP_COMPUTE, 31, 31, -1));
		computes_sent += 2;
		set_vertex_count(6'd1);
		pending_requests.push_back(make_req(OP_COMPUTE, 0, 0, 0));
		computes_sent++;
		set_vertex_count(6'd0);
		pending_requests.push_back(make_req(OP_COMPUTE, 0, 0, 0));
		computes_sent++;
		set_vertex_count(6'd63);
		// Equal weights: ties go to the lower target, then the lower source.
		pending_requests.push_back(make_req(OP_CLEAR, 0, 0, 0));
		pending_requests.push_back(make_req(OP_LOAD, 0, 2, 3));
		pending_requests.push_back(make_req(OP_LOAD, 0, 1, 3));
		pending_requests.push_back(make_req(OP_LOAD, 1, 2, 3));
		pending_requests.push_back(make_req(OP_LOAD, 2, 3, 3));
		pending_requests.push_back(make_req(OP_LOAD, 1, 3, 3));
		pending_requests.push_back(make_req(OP_COMPUTE, 0, 0, 0));
		computes_sent++;
		set_vertex_count(6'd4);
		pending_requests.push_back(make_req(OP_COMPUTE, 0, 0, 0));
		computes_sent++;

		// Extreme weights in both directions on a 32-vertex chain.
		set_vertex_count(6'd32);
		pending_requests.push_back(make_req(OP_CLEAR, 0, 0, 0));
		for (int i = 0; i < 31; i++)
			pending_requests.push_back(make_req(OP_LOAD, i, i + 1, 32767));
		pending_requests.push_back(make_req(OP_COMPUTE, 0, 0, 0));
		pending_requests.push_back(make_req(OP_CLEAR, 0, 0, 0));
		for (int i = 0; i < 31; i++)
			pending_requests.push_back(make_req(OP_LOAD, i, i + 1, -32768));
		pending_requests.push_back(make_req(OP_COMPUTE, 0, 0, 0));
		computes_sent += 2;

		// Random phases, mostly small graphs, the last at full size.
		for (int ph = 0; ph < 8; ph++) begin
			set_vertex_count(ph == 7 ? 6'd32 : 6'($urandom_range(2, 10)));
			queue_graph(model_vcount, $urandom_range(4, 9), ph[0] ? 32767 : 20);
			queue_graph(model_vcount, $urandom_range(2, 6), 9);
			if (ph == 3)
				pending_requests.push_back(32'hFFFF_FFFF);
		end

		while (pending_requests.size() > 0 || s_tvalid)
			@(posedge clk);
		driver_done = 1;
		while (expected_rows.size() > 0)
			@(posedge clk);
		repeat (LOAD_SETTLE) @(posedge clk);
		$display("Covered %0d tree computations and %0d result rows,", computes_sent,
			rows_checked);
		$display("with loads, clears, an unused code and vertex counts 0 to 63.");
		if (error_count == 0)
			$display("PASS prim_minimum_spanning_tree");
		else
			$display("FAIL prim_minimum_spanning_tree");
		$finish;
	end

	// Watchdog.
	initial begin
		#4000000;
		$display("FAIL prim_minimum_spanning_tree");
		$finish;
	end
endmodule

// ===== filelist.f =====
rtl/core/prim_mst_pkg.sv
rtl/core/prim_mst_front.sv
rtl/core/prim_mst_back.sv
rtl/core/prim_minimum_spanning_tree.sv
rtl/core/prim_mst_checker.sv
sim/tb_prim_minimum_spanning_tree.sv
